// ===== sv/ght_pkg.sv =====
// Shared definitions for the generational handle table.
// Operation and status codes, default sizes and the controller/datapath link types.
`timescale 1ns / 1ps

package ght_pkg;

  // Default sizes; the top level takes these as parameter defaults.
  localparam int unsigned SLOTS_DEF        = 1024;
  localparam int unsigned VERSION_BITS_DEF = 32;

  // Fixed field widths of the request and response beats.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HVER_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
  localparam logic [OP_W-1:0] OP_VALIDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY  = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the request, read slot and stack top
    logic pop_read;  // read the slot named by the popped stack entry
    logic exec;      // decide, update tables and counters, load the response
  } ght_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_needed;  // incoming create will reuse a freed slot
    logic out_free;    // response register can take a new beat
  } ght_stat_t;

endpackage

// ===== sv/ght_if.sv =====
// Request and response channel interfaces of the generational handle table.
// Depends on ght_pkg for field widths.
`timescale 1ns / 1ps

interface ght_req_if import ght_pkg::*; #(
  parameter int unsigned IDX_W = 10
) ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  handle_index;
  logic [HVER_W-1:0] handle_version;

  modport source (output valid, output op, output handle_index, output handle_version,
                  input ready);
  modport sink   (input valid, input op, input handle_index, input handle_version,
                  output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; #(
  parameter int unsigned IDX_W = 10
) ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    out_index;
  logic [HVER_W-1:0]   out_version;
  logic                ok;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output out_index, output out_version, output ok,
                  output status, input ready);
  modport sink   (input valid, input out_index, input out_version, input ok,
                  input status, output ready);
endinterface

// ===== sv/ght_ctrl.sv =====
// Sequencing state machine of the generational handle table.
// Depends on ght_pkg for the command and status structs.
`timescale 1ns / 1ps

module ght_ctrl import ght_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  ght_stat_t stat_i,
  output ght_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = stat_i.pop_needed ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd_o.pop_read = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        // Hold here while the previous response is still waiting.
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ght_dp.sv =====
// Datapath of the generational handle table: slot and free-stack memories,
// counters, handle check and response register. Depends on ght_pkg.
`timescale 1ns / 1ps

module ght_dp import ght_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned VERSION_BITS = VERSION_BITS_DEF,
  parameter int unsigned IDX_W        = $clog2(SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ght_cmd_t            cmd_i,
  output ght_stat_t           stat_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [IDX_W-1:0]    handle_index_i,
  input  logic [HVER_W-1:0]   handle_version_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IDX_W-1:0]    out_index_o,
  output logic [HVER_W-1:0]   out_version_o,
  output logic                ok_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned VER_W = VERSION_BITS;

  // Tables; contents are only used for entries written earlier.
  logic             slot_live_mem [SLOTS];
  logic [VER_W-1:0] slot_ver_mem  [SLOTS];
  logic [IDX_W-1:0] stack_mem     [SLOTS];

  logic [CNT_W-1:0] slots_in_use_q, slots_in_use_d;
  logic [CNT_W-1:0] free_count_q, free_count_d;

  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [HVER_W-1:0] ver_q;

  logic             live_rd_q;
  logic [VER_W-1:0] ver_rd_q;
  logic [IDX_W-1:0] stack_rd_q;

  logic                out_valid_q;
  logic [IDX_W-1:0]    out_index_q, out_index_d;
  logic [HVER_W-1:0]   out_version_q, out_version_d;
  logic                ok_q, ok_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic             slot_we, stack_we;
  logic [IDX_W-1:0] slot_wa;
  logic             slot_wlive;
  logic [VER_W-1:0] slot_wver;
  logic [CNT_W-1:0] fc_dec;
  logic             handle_valid;
  logic [VER_W-1:0] ver_inc;

  assign fc_dec  = free_count_q - CNT_W'(1);
  assign ver_inc = ver_rd_q + VER_W'(1);

  assign stat_o.pop_needed = (op_i == OP_CREATE) && (free_count_q != '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      idx_q <= handle_index_i;
      ver_q <= handle_version_i;
    end
  end

  // Slot memory: read at the handle index or at the popped index, one write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      live_rd_q <= slot_live_mem[handle_index_i];
      ver_rd_q  <= slot_ver_mem[handle_index_i];
    end else if (cmd_i.pop_read) begin
      live_rd_q <= slot_live_mem[stack_rd_q];
      ver_rd_q  <= slot_ver_mem[stack_rd_q];
    end
    if (slot_we) begin
      slot_live_mem[slot_wa] <= slot_wlive;
      slot_ver_mem[slot_wa]  <= slot_wver;
    end
  end

  // Free stack: top read at capture, push on a successful destroy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      stack_rd_q <= stack_mem[fc_dec[IDX_W-1:0]];
    end
    if (stack_we) begin
      stack_mem[free_count_q[IDX_W-1:0]] <= idx_q;
    end
  end

  assign handle_valid = (CNT_W'(idx_q) < slots_in_use_q) && live_rd_q &&
                        (HVER_W'(ver_rd_q) == ver_q);

  always_comb begin
    slots_in_use_d = slots_in_use_q;
    free_count_d   = free_count_q;
    slot_we        = 1'b0;
    stack_we       = 1'b0;
    slot_wa        = idx_q;
    slot_wlive     = 1'b0;
    slot_wver      = ver_rd_q;
    out_index_d    = '0;
    out_version_d  = '0;
    ok_d           = 1'b0;
    status_d       = STATUS_INVALID;
    case (op_q)
      OP_CREATE: begin
        if (free_count_q != '0) begin
          // Reuse the most recently freed slot with the next version.
          slot_we       = cmd_i.exec;
          slot_wa       = stack_rd_q;
          slot_wlive    = 1'b1;
          slot_wver     = ver_inc;
          free_count_d  = fc_dec;
          out_index_d   = stack_rd_q;
          out_version_d = HVER_W'(ver_inc);
          ok_d          = 1'b1;
          status_d      = STATUS_OK;
        end else if (slots_in_use_q < CNT_W'(SLOTS)) begin
          slot_we        = cmd_i.exec;
          slot_wa        = slots_in_use_q[IDX_W-1:0];
          slot_wlive     = 1'b1;
          slot_wver      = '0;
          slots_in_use_d = slots_in_use_q + CNT_W'(1);
          out_index_d    = slots_in_use_q[IDX_W-1:0];
          ok_d           = 1'b1;
          status_d       = STATUS_OK;
        end else begin
          status_d = STATUS_FULL;
        end
      end
      OP_VALIDATE: begin
        if (handle_valid) begin
          ok_d     = 1'b1;
          status_d = STATUS_OK;
        end
      end
      OP_DESTROY: begin
        if (handle_valid && (free_count_q < CNT_W'(SLOTS))) begin
          slot_we      = cmd_i.exec;
          stack_we     = cmd_i.exec;
          free_count_d = free_count_q + CNT_W'(1);
          ok_d         = 1'b1;
          status_d     = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= '0;
      free_count_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        slots_in_use_q <= slots_in_use_d;
        free_count_q   <= free_count_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_index_q   <= out_index_d;
      out_version_q <= out_version_d;
      ok_q          <= ok_d;
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_version_o = out_version_q;
  assign ok_o          = ok_q;
  assign status_o      = status_q;

endmodule

// ===== sv/generational_handle_table_top.sv =====
// Top level of the generational handle table: controller plus datapath.
// Depends on ght_pkg, ght_if, ght_ctrl and ght_dp.
//
// Usage. Requests arrive as beats on req_i (op, handle_index, handle_version);
// every request yields exactly one response beat on rsp_o (out_index,
// out_version, ok, status). A create returns a fresh handle, reusing the most
// recently destroyed slot with its version advanced, or the next unused slot
// with version zero; when every slot is in use it answers with the full status.
// Validate checks a handle; destroy of a valid handle frees its slot.
//
// Timing. One request is in flight at a time. Validate, destroy and a create that
// takes an unused slot pass through capture and then the final step, which loads
// the response register. A create that reuses a freed slot passes an extra step
// between the two: the free stack is read first, then the slot memory at the popped
// index, since both tables sit in single-read synchronous memories.
//
// Reset clears the slot-in-use and free counters and the response valid flag; table
// entries are never used before being written, so no clearing pass is needed. When the
// receiver stalls, the response holds in its register and a new request is still
// accepted; that request waits in the final step until the register drains.
`timescale 1ns / 1ps

module generational_handle_table_top import ght_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned VERSION_BITS = VERSION_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  ght_req_if.sink   req_i,
  ght_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  ght_cmd_t  cmd;
  ght_stat_t stat;

  // The controller owns request flow control; the datapath owns the response register.
  ght_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ght_dp #(
    .SLOTS        (SLOTS),
    .VERSION_BITS (VERSION_BITS),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (req_i.op),
    .handle_index_i   (req_i.handle_index),
    .handle_version_i (req_i.handle_version),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .out_index_o      (rsp_o.out_index),
    .out_version_o    (rsp_o.out_version),
    .ok_o             (rsp_o.ok),
    .status_o         (rsp_o.status)
  );

endmodule

// ===== sv/ght_sva.sv =====
// Port-level checks of the generational handle table, attached by bind.
// Depends on ght_pkg and generational_handle_table_top.
`timescale 1ns / 1ps

module ght_sva import ght_pkg::*; #(
  parameter int unsigned VERSION_BITS = VERSION_BITS_DEF,
  parameter int unsigned IDX_W        = 10
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [IDX_W-1:0]    rsp_out_index_i,
  input logic [HVER_W-1:0]   rsp_out_version_i,
  input logic                rsp_ok_i,
  input logic [STATUS_W-1:0] rsp_status_i
);

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in progress");

  // A stalled response beat keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_out_index_i) &&
      $stable(rsp_out_version_i) && $stable(rsp_ok_i) && $stable(rsp_status_i))
    else $error("stalled response changed");

  // The ok flag agrees with the status code.
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_ok_i == (rsp_status_i == STATUS_OK)))
    else $error("ok and status disagree");

  // A failed request carries no handle, and versions stay within their width.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((rsp_out_version_i >> VERSION_BITS) == '0) &&
      (rsp_ok_i || ((rsp_out_index_i == '0) && (rsp_out_version_i == '0))))
    else $error("bad handle fields in response");

endmodule

bind generational_handle_table_top ght_sva #(
  .VERSION_BITS (VERSION_BITS),
  .IDX_W        (IDX_W)
) u_ght_sva (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_out_index_i   (rsp_o.out_index),
  .rsp_out_version_i (rsp_o.out_version),
  .rsp_ok_i          (rsp_o.ok),
  .rsp_status_i      (rsp_o.status)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for generational_handle_table_top: directed, random, back-pressure
// and table-full runs, each response beat checked against a predictor of the handle table.
// Depends on ght_pkg, the ght_req_if / ght_rsp_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb import ght_pkg::*; ();

  localparam int unsigned IDX_W = $clog2(SLOTS_DEF);

  // Op code 3 has no meaning; the block answers it as an invalid request.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Versions count modulo 2^VERSION_BITS.
  localparam logic [HVER_W-1:0] VER_MASK = HVER_W'((64'd1 << VERSION_BITS_DEF) - 64'd1);

  // The longest quiet spell in a correct run is the deliberate receiver hold-off;
  // the watchdog limit is many times that.
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Idle probability of each side, in percent.
  localparam int unsigned IDLE_PCT = 9;

  typedef struct packed {
    logic [IDX_W-1:0]    out_index;
    logic [HVER_W-1:0]   out_version;
    logic                ok;
    logic [STATUS_W-1:0] status;
  } rsp_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic [HVER_W-1:0] ver;
  } handle_t;

  logic clk_i;
  logic rst_ni;

  ght_req_if #(.IDX_W(IDX_W)) req_if ();
  ght_rsp_if #(.IDX_W(IDX_W)) rsp_if ();

  generational_handle_table_top #(
    .SLOTS        (SLOTS_DEF),
    .VERSION_BITS (VERSION_BITS_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the slot table and the free stack.
  // ---------------------------------------------------------------------------
  bit              slot_live  [SLOTS_DEF];
  bit [HVER_W-1:0] slot_ver   [SLOTS_DEF];
  bit [IDX_W-1:0]  free_stack [SLOTS_DEF];
  int unsigned     in_use;
  int unsigned     free_depth;

  // Responses predicted for accepted request beats, oldest first.
  rsp_beat_t expected_rsp[$];
  rsp_beat_t last_predicted;
  rsp_beat_t want;

  // Handles the stimulus knows to be live, and a few that were destroyed.
  handle_t live_handles[$];
  handle_t stale_handles[$];

  // Run-wide flags and counters.
  bit no_idle;
  bit stall_hold;
  int fail_count;
  int n_req, n_rsp, n_create_ok, n_full, n_check_ok, n_destroy_ok, n_invalid;

  function automatic bit handle_is_live(input logic [IDX_W-1:0] idx,
                                        input logic [HVER_W-1:0] ver);
    if (idx >= in_use) return 1'b0;
    return slot_live[idx] && (slot_ver[idx] == ver);
  endfunction

  // Applies one request to the predicted table and returns the response it earns.
  function automatic rsp_beat_t step_handle_table(input logic [OP_W-1:0] op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [HVER_W-1:0] ver);
    rsp_beat_t r;
    logic [IDX_W-1:0] s;
    r.out_index   = '0;
    r.out_version = '0;
    r.ok          = 1'b0;
    r.status      = STATUS_INVALID;
    case (op)
      OP_CREATE: begin
        if (free_depth > 0) begin
          // Reuse the most recently freed slot with its version advanced.
          free_depth--;
          s = free_stack[free_depth];
          slot_live[s]  = 1'b1;
          slot_ver[s]   = (slot_ver[s] + HVER_W'(1)) & VER_MASK;
          r.out_index   = s;
          r.out_version = slot_ver[s];
          r.ok          = 1'b1;
          r.status      = STATUS_OK;
        end else if (in_use < SLOTS_DEF) begin
          s = IDX_W'(in_use);
          slot_live[s] = 1'b1;
          slot_ver[s]  = '0;
          in_use++;
          r.out_index  = s;
          r.ok         = 1'b1;
          r.status     = STATUS_OK;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      OP_VALIDATE: begin
        if (handle_is_live(idx, ver)) begin
          r.ok     = 1'b1;
          r.status = STATUS_OK;
        end
      end
      OP_DESTROY: begin
        if (handle_is_live(idx, ver) && free_depth < SLOTS_DEF) begin
          slot_live[idx]         = 1'b0;
          free_stack[free_depth] = idx;
          free_depth++;
          r.ok     = 1'b1;
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The caller is always at a rising edge when it calls this task,
  // and it returns at the edge where the beat was accepted. Valid stays high on
  // return so that back-to-back beats never see valid dropped and raised in the
  // same time step.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [HVER_W-1:0] ver);
    rsp_beat_t r;
    handle_t h;
    int k;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.op             <= op;
    req_if.handle_index   <= idx;
    req_if.handle_version <= ver;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);

    r = step_handle_table(op, idx, ver);
    expected_rsp.insert(expected_rsp.size(), r);
    last_predicted = r;
    n_req++;

    // Keep the stimulus' view of live and destroyed handles current.
    if (op == OP_CREATE && r.ok) begin
      h.slot = r.out_index;
      h.ver  = r.out_version;
      live_handles.insert(live_handles.size(), h);
      n_create_ok++;
    end else if (op == OP_CREATE) begin
      n_full++;
    end else if (op == OP_DESTROY && r.ok) begin
      for (k = 0; k < live_handles.size(); k++) begin
        if (live_handles[k].slot == idx) begin
          live_handles.delete(k);
          break;
        end
      end
      h.slot = idx;
      h.ver  = ver;
      stale_handles.insert(stale_handles.size(), h);
      if (stale_handles.size() > 64) void'(stale_handles.pop_front());
      n_destroy_ok++;
    end else if (op == OP_VALIDATE && r.ok) begin
      n_check_ok++;
    end else begin
      n_invalid++;
    end
  endtask

  // Stops offering beats and waits until every predicted response has arrived.
  // The queue is looked at on falling edges, after the checker has run.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready with random idling, a long hold-off on request, and
  // no idling at all while no_idle is set.
  // ---------------------------------------------------------------------------
  initial begin : ready_driver
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_hold) begin
        stall_hold = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Each accepted response beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      if (expected_rsp.size() == 0) begin
        $error("response beat with no request outstanding");
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_if.out_index !== want.out_index) begin
          $error("out_index: expected %0d, actual %0d", want.out_index, rsp_if.out_index);
          fail_count++;
        end
        if (rsp_if.out_version !== want.out_version) begin
          $error("out_version: expected 0x%08h, actual 0x%08h", want.out_version,
                 rsp_if.out_version);
          fail_count++;
        end
        if (rsp_if.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, rsp_if.ok);
          fail_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any beat on either channel.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked beats: an empty table, fresh creates, exact and near-miss handles,
  // double destroy, LIFO reuse with version advance, and the unused op code.
  task automatic test_directed();
    send_req(OP_VALIDATE, '0, '0);               // nothing in use yet
    send_req(OP_DESTROY, '0, '0);
    send_req(OP_UNUSED, '1, '1);                 // ignored op, all fields high
    send_req(OP_CREATE, '0, '0);                 // slot 0, version 0
    send_req(OP_CREATE, '1, '1);                 // slot 1
    send_req(OP_CREATE, '0, '0);                 // slot 2
    send_req(OP_VALIDATE, 10'd1, 32'd0);
    send_req(OP_VALIDATE, 10'd1, 32'd1);         // wrong version
    send_req(OP_VALIDATE, 10'd1, 32'hFFFF_FFFF);
    send_req(OP_VALIDATE, 10'd3, 32'd0);         // index past the slots in use
    send_req(OP_VALIDATE, '1, '1);
    send_req(OP_DESTROY, 10'd1, 32'd0);
    send_req(OP_VALIDATE, 10'd1, 32'd0);         // slot is dead now
    send_req(OP_DESTROY, 10'd1, 32'd0);          // second destroy is refused
    send_req(OP_DESTROY, 10'd2, 32'd0);
    send_req(OP_CREATE, '0, '0);                 // reuses slot 2, version 1
    send_req(OP_CREATE, '0, '0);                 // reuses slot 1, version 1
    send_req(OP_CREATE, '0, '0);                 // stack empty again: slot 3
    send_req(OP_VALIDATE, 10'd2, 32'd1);
    send_req(OP_VALIDATE, 10'd2, 32'd0);         // stale version of a reused slot
    send_req(OP_DESTROY, 10'd0, 32'h8000_0000);
    send_req(OP_UNUSED, '0, '0);
    drain_responses();
  endtask

  // Mostly well-formed traffic on known handles, with stale and corrupted handles,
  // raw noise and a sprinkling of the unused op. Creates stop at live_cap live
  // handles so that slots keep being recycled.
  task automatic random_ops(input int count, input int live_cap);
    int pick;
    int k;
    handle_t h;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if (live_handles.size() < live_cap || live_handles.size() == 0) begin
          send_req(OP_CREATE, IDX_W'($urandom_range(0, SLOTS_DEF - 1)), $urandom);
        end else begin
          h = live_handles[$urandom_range(0, live_handles.size() - 1)];
          send_req(OP_DESTROY, h.slot, h.ver);
        end
      end else if (pick < 74 && live_handles.size() > 0) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        send_req((pick < 52) ? OP_VALIDATE : OP_DESTROY, h.slot, h.ver);
      end else if (pick < 82 && stale_handles.size() > 0) begin
        h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
        send_req(pick[0] ? OP_VALIDATE : OP_DESTROY, h.slot, h.ver);
      end else if (pick < 88 && live_handles.size() > 0) begin
        // A live handle with one version bit flipped must be refused.
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        k = $urandom_range(0, HVER_W - 1);
        send_req(pick[0] ? OP_VALIDATE : OP_DESTROY, h.slot, h.ver ^ (32'h1 << k));
      end else if (pick < 97) begin
        send_req(OP_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, SLOTS_DEF - 1)),
                 $urandom);
      end else begin
        send_req(OP_UNUSED, IDX_W'($urandom_range(0, SLOTS_DEF - 1)), $urandom);
      end
    end
  endtask

  // Random traffic: first a stretch where neither side idles, then random idling
  // on both sides, with a full pause in the middle.
  task automatic test_random();
    no_idle = 1'b1;
    random_ops(60, 48);
    no_idle = 1'b0;
    random_ops(80, 48);
    drain_responses();
    random_ops(60, 24);
    drain_responses();
  endtask

  // The receiver stops taking responses for a long stretch while beats keep
  // coming, so the response register and the request stage both fill and the
  // block has to hold off its input.
  task automatic test_backpressure();
    handle_t h;
    stall_hold = 1'b1;
    send_req(OP_CREATE, '0, '0);
    h = live_handles[live_handles.size() - 1];
    send_req(OP_VALIDATE, h.slot, h.ver);
    send_req(OP_DESTROY, h.slot, h.ver);
    send_req(OP_CREATE, '0, '0);                 // takes the slot just freed
    random_ops(8, 48);
    drain_responses();
  endtask

  // Creates until the table reports full, then works at the limit: refused
  // creates, the top slot, a free and reuse, and random churn on a full table.
  task automatic test_fill_table();
    do begin
      send_req(OP_CREATE, IDX_W'($urandom_range(0, SLOTS_DEF - 1)), $urandom);
    end while (last_predicted.status != STATUS_FULL);
    send_req(OP_CREATE, '1, '1);                 // still full
    send_req(OP_VALIDATE, '1, '0);               // top slot was fresh: version 0
    send_req(OP_VALIDATE, '1, 32'd1);
    send_req(OP_DESTROY, '1, '0);
    send_req(OP_CREATE, '0, '0);                 // top slot again, version 1
    send_req(OP_CREATE, '0, '0);                 // full
    drain_responses();
    random_ops(40, SLOTS_DEF + 1);
    drain_responses();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing.
  // ---------------------------------------------------------------------------
  initial begin
    no_idle                = 1'b0;
    stall_hold             = 1'b0;
    fail_count             = 0;
    in_use                 = 0;
    free_depth             = 0;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.op             <= OP_CREATE;
    req_if.handle_index   <= '0;
    req_if.handle_version <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();
    test_fill_table();

    // Give a stray extra beat time to show up.
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d requests and %0d responses: %0d creates, %0d full refusals,",
             n_req, n_rsp, n_create_ok, n_full);
    $display("  %0d good validates, %0d destroys and %0d refused or ignored requests.",
             n_check_ok, n_destroy_ok, n_invalid);
    if (fail_count == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d responses missing", fail_count, expected_rsp.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
